>>> rtl/core/bsbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsbp_pkg
// Shared types and constants of the box screen bounds projector.
// ----------------------------------------------------------------------------
package bsbp_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CAMERA_POS = 3'd0,
    REG_VIEW_DIR   = 3'd1,
    REG_RIGHT_AXIS = 3'd2,
    REG_UP_AXIS    = 3'd3,
    REG_FOV_TAN    = 3'd4,
    REG_SCR_WIDTH  = 3'd5,
    REG_SCR_HEIGHT = 3'd6
  } bsbp_reg_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 60;
  localparam int unsigned CAM_W      = 60;
  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned TAN_W      = 16;
  localparam int unsigned SCR_W      = 13;

  localparam logic [TAN_W-1:0] TAN_RESET    = 16'd4096;
  localparam logic [SCR_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [SCR_W-1:0] HEIGHT_RESET = 13'd480;

  // near plane 0.1 as Q.8 raw 26, held in Q.22
  localparam int unsigned NEAR_Q22  = 26 << 14;
  // fraction bits dropped from Q.22 dot products
  localparam int unsigned DOT_SHIFT = 14;
  // offset saturates at 2^OFF_BITS
  localparam int unsigned OFF_BITS  = 40;
  localparam int unsigned Q_W       = OFF_BITS + 1;
  // numerator is h * mag * 2^NUM_SHIFT
  localparam int unsigned NUM_SHIFT = 19;
  localparam int unsigned REM_SHIFT = OFF_BITS - NUM_SHIFT;
  // screen coordinate width in Q.8
  localparam int unsigned SCRN_W    = 43;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned OUT_DATA_W = 4 * PIX_W;

  // side information that travels with each corner
  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
    logic first;
    logic lastc;
    logic last_box;
  } bsbp_tag_t;

endpackage

>>> rtl/core/bsbp_proj_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsbp_proj_div
// Pipelined restoring divider, two lanes sharing one divisor, one quotient
// bit per stage, quotient saturated at 2^40.
// ----------------------------------------------------------------------------
module bsbp_proj_div #(
  parameter int unsigned DEN_W = 41
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  bsbp_pkg::bsbp_tag_t           tag_i,
  input  logic [DEN_W-1:0]              den_i,
  input  logic [DEN_W-4:0]              num_x_i,
  input  logic [DEN_W-4:0]              num_y_i,
  output logic                          valid_o,
  output bsbp_pkg::bsbp_tag_t           tag_o,
  output logic [bsbp_pkg::Q_W-1:0]      q_x_o,
  output logic [bsbp_pkg::Q_W-1:0]      q_y_o
);

  localparam int unsigned STEPS = bsbp_pkg::OFF_BITS;
  localparam int unsigned CMP_W = DEN_W + bsbp_pkg::REM_SHIFT;

  logic [STEPS:0]      vld_q;
  bsbp_pkg::bsbp_tag_t tag_q  [STEPS+1];
  logic [DEN_W-1:0]    den_q  [STEPS+1];
  logic                ovf_x_q[STEPS+1];
  logic                ovf_y_q[STEPS+1];
  logic [DEN_W-1:0]    rem_x_q[STEPS+1];
  logic [DEN_W-1:0]    rem_y_q[STEPS+1];
  logic [STEPS-1:0]    ql_x_q [STEPS+1];
  logic [STEPS-1:0]    ql_y_q [STEPS+1];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEPS-1:0], valid_i};
    end
  end

  // entry stage: overflow check and initial partial remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0]   <= tag_i;
      den_q[0]   <= den_i;
      ovf_x_q[0] <= CMP_W'(num_x_i) >= {den_i, {bsbp_pkg::REM_SHIFT{1'b0}}};
      ovf_y_q[0] <= CMP_W'(num_y_i) >= {den_i, {bsbp_pkg::REM_SHIFT{1'b0}}};
      rem_x_q[0] <= DEN_W'(num_x_i >> bsbp_pkg::REM_SHIFT);
      rem_y_q[0] <= DEN_W'(num_y_i >> bsbp_pkg::REM_SHIFT);
      ql_x_q[0]  <= {num_x_i[bsbp_pkg::REM_SHIFT-1:0], {bsbp_pkg::NUM_SHIFT{1'b0}}};
      ql_y_q[0]  <= {num_y_i[bsbp_pkg::REM_SHIFT-1:0], {bsbp_pkg::NUM_SHIFT{1'b0}}};
    end
  end

  // one quotient bit per stage; numerator bits shift out as quotient bits shift in
  for (genvar i = 1; i <= STEPS; i++) begin : g_step
    logic [DEN_W:0] t_x, t_y;
    logic           ge_x, ge_y;

    always_comb begin
      t_x  = {rem_x_q[i-1], ql_x_q[i-1][STEPS-1]};
      t_y  = {rem_y_q[i-1], ql_y_q[i-1][STEPS-1]};
      ge_x = t_x >= {1'b0, den_q[i-1]};
      ge_y = t_y >= {1'b0, den_q[i-1]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[i]   <= tag_q[i-1];
        den_q[i]   <= den_q[i-1];
        ovf_x_q[i] <= ovf_x_q[i-1];
        ovf_y_q[i] <= ovf_y_q[i-1];
        rem_x_q[i] <= ge_x ? DEN_W'(t_x - {1'b0, den_q[i-1]}) : DEN_W'(t_x);
        rem_y_q[i] <= ge_y ? DEN_W'(t_y - {1'b0, den_q[i-1]}) : DEN_W'(t_y);
        ql_x_q[i]  <= {ql_x_q[i-1][STEPS-2:0], ge_x};
        ql_y_q[i]  <= {ql_y_q[i-1][STEPS-2:0], ge_y};
      end
    end
  end

  // saturated quotients
  assign valid_o = vld_q[STEPS];
  assign tag_o   = tag_q[STEPS];
  assign q_x_o   = ovf_x_q[STEPS] ? {1'b1, {STEPS{1'b0}}} : {1'b0, ql_x_q[STEPS]};
  assign q_y_o   = ovf_y_q[STEPS] ? {1'b1, {STEPS{1'b0}}} : {1'b0, ql_y_q[STEPS]};

endmodule

>>> rtl/core/box_screen_bounds_projector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_screen_bounds_projector_top
// Projects the eight corners of an axis-aligned box through a perspective
// camera and reports the covering screen rectangle.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | tdata: box min x,y,z, max x,y,z; tlast: last box
//  m_axis    | out       | tdata: left, top, width, height; tuser: visible;
//            |           | tlast: last box
//  cfg       | in        | register index and write data, always ready
//
//  The corner sequencer feeds one corner per cycle, unless the output stalls,
//  into a shared projection pipeline (products, dot sums, depth multiply,
//  40-stage divider, min/max); a new box is accepted while the last corner
//  of the previous box issues, so boxes follow each other without gaps.
//  Reset clears valid bits and loads register defaults; no clearing pass.
//  A stalled output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module box_screen_bounds_projector_top #(
  parameter int unsigned COORD_WIDTH = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // box min x,y,z then max x,y,z, COORD_WIDTH bits each, zero padded
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  input  logic                                 s_axis_tlast_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // rect_left, rect_top, rect_width, rect_height, 16 bits each
  output logic [bsbp_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // visible
  output logic                                 m_axis_tuser_o,
  output logic                                 m_axis_tlast_o,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bsbp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bsbp_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned C      = COORD_WIDTH;
  localparam int unsigned REL_W  = C + 1;
  localparam int unsigned PROD_W = C + 17;
  localparam int unsigned DOT_W  = C + 19;
  localparam int unsigned D8_W   = DOT_W - bsbp_pkg::DOT_SHIFT;
  localparam int unsigned DEN_W  = D8_W + bsbp_pkg::TAN_W;
  localparam int unsigned NUM_W  = D8_W + bsbp_pkg::SCR_W;
  localparam int unsigned SW     = bsbp_pkg::SCRN_W;
  localparam logic signed [DOT_W-1:0] NearQ22 = DOT_W'(bsbp_pkg::NEAR_Q22);

  // --------------------------------------------------------------------------
  // configuration registers
  logic [bsbp_pkg::CAM_W-1:0]  cam_q;
  logic [3*bsbp_pkg::AXIS_W-1:0] view_q, right_q, up_q;
  logic [bsbp_pkg::TAN_W-1:0]  tan_q;
  logic [bsbp_pkg::SCR_W-1:0]  wid_q, hgt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q   <= '0;
      view_q  <= '0;
      right_q <= '0;
      up_q    <= '0;
      tan_q   <= bsbp_pkg::TAN_RESET;
      wid_q   <= bsbp_pkg::WIDTH_RESET;
      hgt_q   <= bsbp_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      unique case (bsbp_pkg::bsbp_reg_e'(cfg_index_i))
        bsbp_pkg::REG_CAMERA_POS: cam_q   <= cfg_data_i[bsbp_pkg::CAM_W-1:0];
        bsbp_pkg::REG_VIEW_DIR:   view_q  <= cfg_data_i[3*bsbp_pkg::AXIS_W-1:0];
        bsbp_pkg::REG_RIGHT_AXIS: right_q <= cfg_data_i[3*bsbp_pkg::AXIS_W-1:0];
        bsbp_pkg::REG_UP_AXIS:    up_q    <= cfg_data_i[3*bsbp_pkg::AXIS_W-1:0];
        bsbp_pkg::REG_FOV_TAN:    tan_q   <= cfg_data_i[bsbp_pkg::TAN_W-1:0];
        bsbp_pkg::REG_SCR_WIDTH:  wid_q   <= cfg_data_i[bsbp_pkg::SCR_W-1:0];
        bsbp_pkg::REG_SCR_HEIGHT: hgt_q   <= cfg_data_i[bsbp_pkg::SCR_W-1:0];
        default: ;
      endcase
    end
  end

  // unpacked camera and axes
  logic [3*C-1:0]           cam_ext;
  logic signed [C-1:0]      cam_c [3];
  logic signed [15:0]       axis  [3][3];

  assign cam_ext = (3*C)'(cam_q);
  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign cam_c[k]   = cam_ext[k*C +: C];
    assign axis[0][k] = view_q[k*bsbp_pkg::AXIS_W +: bsbp_pkg::AXIS_W];
    assign axis[1][k] = right_q[k*bsbp_pkg::AXIS_W +: bsbp_pkg::AXIS_W];
    assign axis[2][k] = up_q[k*bsbp_pkg::AXIS_W +: bsbp_pkg::AXIS_W];
  end

  // --------------------------------------------------------------------------
  // pipeline enable: everything moves unless the output register is held
  logic m_valid_q;
  logic en;
  assign en = !m_valid_q || m_axis_tready_i;

  // --------------------------------------------------------------------------
  // corner sequencer
  logic                busy_q;
  logic [2:0]          cnt_q;
  logic signed [C-1:0] lo_q [3];
  logic signed [C-1:0] hi_q [3];
  logic                last_q;
  logic                accept;

  assign s_axis_tready_o = en && (!busy_q || cnt_q == 3'd7);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (en) begin
      if (accept) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        busy_q <= cnt_q != 3'd7;
        cnt_q  <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < 3; k++) begin
        lo_q[k] <= s_axis_tdata_i[k*C +: C];
        hi_q[k] <= s_axis_tdata_i[(k+3)*C +: C];
      end
      last_q <= s_axis_tlast_i;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: corner relative to camera
  logic                  s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s7_vld_q;
  bsbp_pkg::bsbp_tag_t   s1_tag_q, s2_tag_q, s3_tag_q, s4_tag_q, s5_tag_q, s7_tag_q;
  logic signed [REL_W-1:0]  rel_q  [3];
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [DOT_W-1:0]  dot_q  [3];
  logic [D8_W-1:0]          depth8_q, mag_x_q, mag_y_q;
  logic [DEN_W-1:0]         den_q;
  logic [NUM_W-1:0]         num_x_q, num_y_q;
  logic signed [SW-1:0]     sx_q, sy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rel_q[k] <= (cnt_q[k] ? REL_W'(hi_q[k]) : REL_W'(lo_q[k])) - REL_W'(cam_c[k]);
      end
      s1_tag_q <= '{vis: 1'b0, neg_x: 1'b0, neg_y: 1'b0,
                    first: cnt_q == 3'd0, lastc: cnt_q == 3'd7, last_box: last_q};
    end
  end

  // stage 2: nine axis products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[a][k] <= PROD_W'(rel_q[k]) * PROD_W'(axis[a][k]);
        end
      end
      s2_tag_q <= s1_tag_q;
    end
  end

  // stage 3: depth, right and up dot sums
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        dot_q[a] <= DOT_W'(prod_q[a][0]) + DOT_W'(prod_q[a][1]) + DOT_W'(prod_q[a][2]);
      end
      s3_tag_q <= s2_tag_q;
    end
  end

  // stage 4: near test, cut to Q.8 magnitudes
  logic [DOT_W-1:0] abs_x, abs_y;
  always_comb begin
    abs_x = dot_q[1][DOT_W-1] ? DOT_W'(-dot_q[1]) : DOT_W'(dot_q[1]);
    abs_y = dot_q[2][DOT_W-1] ? DOT_W'(-dot_q[2]) : DOT_W'(dot_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      depth8_q <= dot_q[0][DOT_W-1:bsbp_pkg::DOT_SHIFT];
      mag_x_q  <= abs_x[DOT_W-1:bsbp_pkg::DOT_SHIFT];
      mag_y_q  <= abs_y[DOT_W-1:bsbp_pkg::DOT_SHIFT];
      s4_tag_q <= '{vis: dot_q[0] > NearQ22, neg_x: dot_q[1][DOT_W-1],
                    neg_y: dot_q[2][DOT_W-1], first: s3_tag_q.first,
                    lastc: s3_tag_q.lastc, last_box: s3_tag_q.last_box};
    end
  end

  // stage 5: divisor and numerators
  logic [bsbp_pkg::TAN_W-1:0] tanv;
  assign tanv = (tan_q == '0) ? bsbp_pkg::TAN_W'(1) : tan_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q    <= DEN_W'(depth8_q) * DEN_W'(tanv);
      num_x_q  <= NUM_W'(hgt_q) * NUM_W'(mag_x_q);
      num_y_q  <= NUM_W'(hgt_q) * NUM_W'(mag_y_q);
      s5_tag_q <= s4_tag_q;
    end
  end

  // stage 6: divider pipeline
  logic                       div_vld;
  bsbp_pkg::bsbp_tag_t        div_tag;
  logic [bsbp_pkg::Q_W-1:0]   q_x, q_y;

  bsbp_proj_div #(
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_vld_q),
    .tag_i   (s5_tag_q),
    .den_i   (den_q),
    .num_x_i (num_x_q),
    .num_y_i (num_y_q),
    .valid_o (div_vld),
    .tag_o   (div_tag),
    .q_x_o   (q_x),
    .q_y_o   (q_y)
  );

  // stage 7: screen coordinates in Q.8
  logic signed [SW-1:0] qx_s, qy_s, off_x, off_y;
  always_comb begin
    qx_s  = $signed(SW'(q_x));
    qy_s  = $signed(SW'(q_y));
    off_x = div_tag.neg_x ? -qx_s : qx_s;
    off_y = div_tag.neg_y ? -qy_s : qy_s;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q     <= $signed(SW'({wid_q, 7'b0})) + off_x;
      sy_q     <= $signed(SW'({hgt_q, 7'b0})) - off_y;
      s7_tag_q <= div_tag;
    end
  end

  // --------------------------------------------------------------------------
  // running min/max over the corners of one box
  logic                 any_q;
  logic signed [SW-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic                 cur_any, nxt_any;
  logic signed [SW-1:0] nxt_min_x, nxt_max_x, nxt_min_y, nxt_max_y;

  always_comb begin
    cur_any   = s7_tag_q.first ? 1'b0 : any_q;
    nxt_min_x = min_x_q;
    nxt_max_x = max_x_q;
    nxt_min_y = min_y_q;
    nxt_max_y = max_y_q;
    if (s7_tag_q.vis) begin
      if (!cur_any || sx_q < min_x_q) nxt_min_x = sx_q;
      if (!cur_any || sx_q > max_x_q) nxt_max_x = sx_q;
      if (!cur_any || sy_q < min_y_q) nxt_min_y = sy_q;
      if (!cur_any || sy_q > max_y_q) nxt_max_y = sy_q;
    end
    nxt_any = cur_any || s7_tag_q.vis;
  end

  logic                 fin_vld_q, fin_any_q, fin_last_q;
  logic signed [SW-1:0] fin_min_x_q, fin_max_x_q, fin_min_y_q, fin_max_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
    end else if (en && s7_vld_q) begin
      any_q <= nxt_any;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s7_vld_q) begin
      min_x_q <= nxt_min_x;
      max_x_q <= nxt_max_x;
      min_y_q <= nxt_min_y;
      max_y_q <= nxt_max_y;
    end
    if (en) begin
      fin_any_q   <= nxt_any;
      fin_last_q  <= s7_tag_q.last_box;
      fin_min_x_q <= nxt_min_x;
      fin_max_x_q <= nxt_max_x;
      fin_min_y_q <= nxt_min_y;
      fin_max_y_q <= nxt_max_y;
    end
  end

  // --------------------------------------------------------------------------
  // conversion to pixels and output register
  function automatic logic [bsbp_pkg::PIX_W-1:0] pix_trunc(input logic signed [SW-1:0] v);
    logic [SW-1:0] mag;
    logic [SW-9:0] m8;
    mag = v[SW-1] ? SW'(-v) : SW'(v);
    m8  = mag[SW-1:8];
    if (!v[SW-1]) begin
      pix_trunc = (m8 > (SW-8)'(32767)) ? 16'h7FFF : m8[15:0];
    end else begin
      pix_trunc = (m8 > (SW-8)'(32768)) ? 16'h8000 : 16'(-m8[15:0]);
    end
  endfunction

  function automatic logic [bsbp_pkg::PIX_W-1:0] pix_span(input logic signed [SW-1:0] hi,
                                                          input logic signed [SW-1:0] lo);
    logic [SW:0] d;
    d = (SW+1)'(hi) - (SW+1)'(lo);
    pix_span = (|d[SW:24]) ? 16'hFFFF : d[23:8];
  endfunction

  logic [bsbp_pkg::OUT_DATA_W-1:0] m_data_q;
  logic                            m_vis_q, m_last_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_vis_q  <= fin_any_q;
      m_last_q <= fin_last_q;
      m_data_q <= fin_any_q ? {pix_span(fin_max_y_q, fin_min_y_q),
                               pix_span(fin_max_x_q, fin_min_x_q),
                               pix_trunc(fin_min_y_q),
                               pix_trunc(fin_min_x_q)} : '0;
    end
  end

  // valid bits of all stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      fin_vld_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= busy_q;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s7_vld_q  <= div_vld;
      fin_vld_q <= s7_vld_q && s7_tag_q.lastc;
      m_valid_q <= fin_vld_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_vis_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

>>> rtl/core/bsbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsbp_checker
// Port-level checks of the box screen bounds projector.
// ----------------------------------------------------------------------------
module bsbp_checker #(
  parameter int unsigned COORD_WIDTH = 20
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid_i,
  input logic                               s_axis_tready_o,
  input logic [bsbp_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  input logic                               m_axis_tuser_o,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i
);

  // held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output transaction changed while stalled");

  // a box with no visible corner reports an empty rectangle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("invisible box with non-zero rectangle");

  // corner sequencer is busy right after a box is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("box accepted while corners still issuing");

  // a held result freezes the pipeline, input included
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input ready while pipeline stalled");

endmodule

bind box_screen_bounds_projector_top bsbp_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_bsbp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);
